// File: hw/rtl/cfcm_pkg.sv
// Package for the CAN frame chunk merge table: sizes, op codes and the structs
// passed between the controller and the chain of slot cells.
// Depends on nothing; every other file imports it.
package cfcm_pkg;

   // Number of slots in the table (1 to 16).
   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Fixed field widths of the words on the ports.
   localparam int ID_W    = 29;
   localparam int LEN_W   = 4;
   localparam int DATA_W  = 64;
   localparam int SLOT_W  = 4;
   localparam int OP_W    = 2;
   localparam int BYTES   = 8;
   localparam int REQ_W   = 104;
   localparam int RSP_W   = 120;

   // Op codes carried in the request tuser.
   localparam logic [OP_W-1:0] OP_RECV    = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_RESP
   } state_type;

   // Search key broadcast to every cell during a scan.
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
   } key_type;

   // Token handed from cell to cell, highest index first.
   typedef struct packed {
      logic              match_hit;
      logic [IDX_W-1:0]  match_idx;
      logic [BYTES-1:0]  match_mask;
      logic              free_hit;
      logic [IDX_W-1:0]  free_idx;
      logic [ID_W-1:0]   rd_id;
      logic [BYTES-1:0]  rd_mask;
      logic [DATA_W-1:0] rd_data;
   } token_type;

   // Table update broadcast to every cell for one cycle.
   typedef struct packed {
      logic              mrg_en;
      logic [IDX_W-1:0]  mrg_idx;
      logic [BYTES-1:0]  mrg_be;
      logic [DATA_W-1:0] mrg_data;
      logic              opn_en;
      logic [IDX_W-1:0]  opn_idx;
      logic [BYTES-1:0]  opn_be;
      logic [DATA_W-1:0] opn_data;
      logic              clr_en;
      logic [IDX_W-1:0]  clr_idx;
      logic [ID_W-1:0]   id;
   } write_type;

endpackage

// File: hw/rtl/can_frame_chunk_merge_table_core.sv
// Top level of the CAN frame chunk merge table: request and result stream
// ports, the controller and the chain of slot cells.
// Depends on cfcm_pkg, cfcm_ctrl and cfcm_cell.

// The table holds SLOT_COUNT slots, each with a frame ID, eight data bytes
// and a byte-valid mask; ID 0 is a free slot and all slots are free after
// reset. Every request word (receive, read or release, chosen by req_tuser)
// sends a token down the row of slot cells from the highest index to the
// lowest, one cell per cycle; the token picks up the highest-indexed slot with
// the frame ID, the lowest free slot above it, and on a read the addressed
// slot. The controller then steps through its states in order for each request:
// SCAN while the token walks the chain, CALC to work out the update, RESP to
// present the result while the cells write, and IDLE to accept again, so a new
// request is taken only once the last result has been taken. Exactly one
// result word comes back for every request word, in order.
module can_frame_chunk_merge_table_core
   import cfcm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Request: tdata holds frame_id[28:0], byte_count[32:29], payload[96:33],
   // slot[100:97], zero fill[103:101]; tuser holds op[1:0].
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [OP_W-1:0]  req_tuser,
   // Result: tdata holds merged_valid[0], merged_slot[4:1], opened_valid[5],
   // opened_slot[9:6], dropped_bytes[13:10], entry_id[42:14],
   // entry_mask[50:43], entry_data[114:51], zero fill[119:115].
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   token_type tok [SLOT_COUNT+1];
   key_type   key;
   write_type wr;
   logic      req_ready;
   logic      rsp_valid;

   assign req_tready = req_ready;
   assign rsp_tvalid = rsp_valid;

   // The token enters the top cell empty.
   assign tok[SLOT_COUNT] = '0;

   cfcm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_tvalid && req_ready),
      .req_op         (req_tuser),
      .req_frame_id   (req_tdata[28:0]),
      .req_byte_count (req_tdata[32:29]),
      .req_payload    (req_tdata[96:33]),
      .req_slot       (req_tdata[100:97]),
      .rsp_accept     (rsp_valid && rsp_tready),
      .tok            (tok[0]),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_word       (rsp_tdata),
      .key            (key),
      .wr             (wr)
   );

   // Row of slot cells; cell i hands its token to cell i-1.
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      cfcm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .key        (key),
         .wr         (wr),
         .tok_in     (tok[i+1]),
         .tok_out    (tok[i])
      );
   end

endmodule

// File: hw/rtl/cfcm_cell.sv
// One slot of the CAN frame chunk merge table: ID, mask and data registers,
// plus one stage of the search token chain. Depends on cfcm_pkg.
module cfcm_cell
   import cfcm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  key_type          key,
   input  write_type        wr,
   input  token_type        tok_in,
   output token_type        tok_out
);

   logic [ID_W-1:0]   id_ff,   id_in;
   logic [BYTES-1:0]  mask_ff, mask_in;
   logic [DATA_W-1:0] data_ff, data_in;
   token_type         pass_ff, pass_in;

   // Token stage: the first matching cell from the top claims the match, and
   // free cells seen before it leave the lowest free index in the token.
   always_comb begin
      pass_in = tok_in;
      if (!tok_in.match_hit) begin
         if (id_ff == key.id) begin
            pass_in.match_hit  = 1'b1;
            pass_in.match_idx  = cell_index;
            pass_in.match_mask = mask_ff;
         end else if (id_ff == '0) begin
            pass_in.free_hit = 1'b1;
            pass_in.free_idx = cell_index;
         end
      end
      if (key.rd_en && (key.rd_idx == cell_index)) begin
         pass_in.rd_id   = id_ff;
         pass_in.rd_mask = mask_ff;
         pass_in.rd_data = data_ff;
      end
   end

   // Slot update: release, append to a match, or claim as a new slot.
   always_comb begin
      id_in   = id_ff;
      mask_in = mask_ff;
      data_in = data_ff;
      if (wr.clr_en && (wr.clr_idx == cell_index)) begin
         id_in   = '0;
         mask_in = '0;
         data_in = '0;
      end else if (wr.mrg_en && (wr.mrg_idx == cell_index)) begin
         mask_in = mask_ff | wr.mrg_be;
         for (int j = 0; j < BYTES; j++) begin
            if (wr.mrg_be[j]) begin
               data_in[8*j +: 8] = wr.mrg_data[8*j +: 8];
            end
         end
      end else if (wr.opn_en && (wr.opn_idx == cell_index)) begin
         id_in   = wr.id;
         mask_in = wr.opn_be;
         for (int j = 0; j < BYTES; j++) begin
            if (wr.opn_be[j]) begin
               data_in[8*j +: 8] = wr.opn_data[8*j +: 8];
            end
         end
      end
   end

   // Slot contents reset to a free, empty slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff   <= '0;
         mask_ff <= '0;
         data_ff <= '0;
      end else begin
         id_ff   <= id_in;
         mask_ff <= mask_in;
         data_ff <= data_in;
      end
   end

   // The token stage is flushed by every scan and needs no reset.
   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
   end

   assign tok_out = pass_ff;

endmodule

// File: hw/rtl/cfcm_ctrl.sv
// Controller of the CAN frame chunk merge table: holds the request, times the
// token scan, works out the table update and the result word.
// Depends on cfcm_pkg.
module cfcm_ctrl
   import cfcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic [OP_W-1:0]   req_op,
   input  logic [ID_W-1:0]   req_frame_id,
   input  logic [LEN_W-1:0]  req_byte_count,
   input  logic [DATA_W-1:0] req_payload,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              rsp_accept,
   input  token_type         tok,
   output logic              req_ready,
   output logic              rsp_valid,
   output logic [RSP_W-1:0]  rsp_word,
   output key_type           key,
   output write_type         wr
);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   fid_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [DATA_W-1:0] payload_ff;
   logic [SLOT_W-1:0] slot_ff;
   write_type         wr_ff, wr_in;
   logic [RSP_W-1:0]  rsp_ff, rsp_in;
   logic              calc_en;
   logic              scan_done;

   // Decode of the held request.
   logic              sel_ok;
   logic [LEN_W-1:0]  len;
   logic              recv_ok;
   logic              match_ok;
   logic [LEN_W-1:0]  start;
   logic [LEN_W-1:0]  room;
   logic [LEN_W-1:0]  used;
   logic [LEN_W-1:0]  rem;
   logic              open_ok;
   logic [LEN_W-1:0]  dropped;

   assign scan_done = (cnt_ff == IDX_W'(SLOT_COUNT - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_SCAN;
         ST_SCAN: if (scan_done) state_in = ST_CALC;
         ST_CALC: state_in = ST_RESP;
         ST_RESP: if (rsp_accept) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      calc_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCAN: ;
         ST_CALC: calc_en = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // Scan counter: steps once for each cell until the token leaves cell 0.
   always_comb begin
      cnt_in = '0;
      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Request holding registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_op;
         fid_ff     <= req_frame_id;
         len_ff     <= req_byte_count;
         payload_ff <= req_payload;
         slot_ff    <= req_slot;
      end
   end

   // Key seen by the cells; reads pick the slot on the way through the chain.
   assign sel_ok     = (32'(slot_ff) < SLOT_COUNT);
   assign key.id     = fid_ff;
   assign key.rd_en  = (op_ff == OP_READ) && sel_ok;
   assign key.rd_idx = IDX_W'(slot_ff);

   // Merge arithmetic: how many bytes fit after the match, how many are left.
   always_comb begin
      len      = (len_ff > LEN_W'(BYTES)) ? LEN_W'(BYTES) : len_ff;
      recv_ok  = (op_ff == OP_RECV) && (fid_ff != '0) && (len != '0);
      match_ok = recv_ok && tok.match_hit && !tok.match_mask[BYTES-1];
      start    = '0;
      for (int j = 0; j < BYTES; j++) begin
         if (tok.match_mask[j]) begin
            start = LEN_W'(j + 1);
         end
      end
      room    = LEN_W'(BYTES) - start;
      used    = match_ok ? ((len < room) ? len : room) : '0;
      rem     = len - used;
      open_ok = recv_ok && (rem != '0) && tok.free_hit;
      dropped = (recv_ok && (rem != '0) && !tok.free_hit) ? rem : '0;
   end

   // Table update, worked out in CALC and registered on its way to the cells.
   always_comb begin
      wr_in          = '0;
      wr_in.id       = fid_ff;
      wr_in.mrg_idx  = tok.match_idx;
      wr_in.opn_idx  = tok.free_idx;
      wr_in.clr_idx  = IDX_W'(slot_ff);
      wr_in.mrg_data = payload_ff << {start[2:0], 3'b000};
      wr_in.opn_data = payload_ff >> {used, 3'b000};
      for (int j = 0; j < BYTES; j++) begin
         wr_in.mrg_be[j] = (LEN_W'(j) >= start) && (LEN_W'(j) < start + used);
         wr_in.opn_be[j] = (LEN_W'(j) < rem);
      end
      if (calc_en) begin
         wr_in.mrg_en = match_ok;
         wr_in.opn_en = open_ok;
         wr_in.clr_en = (op_ff == OP_RELEASE) && sel_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
      end else begin
         wr_ff <= wr_in;
      end
   end

   assign wr = wr_ff;

   // Result word, packed from the lowest bit up.
   always_comb begin
      rsp_in = '0;
      rsp_in[0]      = match_ok;
      rsp_in[4:1]    = match_ok ? SLOT_W'(tok.match_idx) : '0;
      rsp_in[5]      = open_ok;
      rsp_in[9:6]    = open_ok ? SLOT_W'(tok.free_idx) : '0;
      rsp_in[13:10]  = dropped;
      rsp_in[42:14]  = tok.rd_id;
      rsp_in[50:43]  = tok.rd_mask;
      rsp_in[114:51] = tok.rd_data;
   end

   always_ff @(posedge clock) begin
      if (calc_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule
